FILE: rtl/sfr_pkg.sv
// Shared types and constants for the sum-checked frame receiver.
// Holds the command and status structs between controller and datapath.
// No dependencies.
package sfr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned SUM_W   = 17;

  // Commands from the controller to the datapath, one pulse per action.
  typedef struct packed {
    logic start;      // marker seen: restart sum and byte count
    logic take_cmd;   // latch command byte
    logic take_len;   // latch length byte
    logic take_data;  // store payload byte
    logic take_ckhi;  // latch checksum high byte
    logic take_cklo;  // check low byte, arm result run
    logic emit_load;  // load one result into the output register
  } sfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic marker_hit;  // incoming byte equals the frame marker
    logic len_zero;    // incoming byte is zero (length phase)
    logic data_done;   // this payload byte is the final one
    logic run_last;    // next result to load ends the run
    logic out_free;    // output register can take a result
  } sfr_stat_t;

endpackage

FILE: rtl/sum_checked_frame_receiver.sv
// Top level of the sum-checked frame receiver.
// Instantiates sfr_ctrl and sfr_dp; uses sfr_pkg.
//
// Takes one received byte per beat on the rx channel. A frame is marker,
// command, length, length payload bytes, checksum high, checksum low; the
// checksum is the 17-bit sum of marker, command, length and payload bytes.
// Bytes outside a frame other than the marker are dropped. While a frame is
// received, rx_ready_o stays high, so no frame byte is held back. Once the
// low checksum byte is taken, rx_ready_o drops and the controller drains
// the run from the payload store through the output register, one result
// per cycle while res_ready_i is high. A run holds max(1, min(length,
// MAX_PAYLOAD)) results, all read through the single store read port.
// A length above MAX_PAYLOAD keeps only the first MAX_PAYLOAD bytes and
// flags the frame oversize and failed. The frame marker register (reset
// 0xFF) is to be written with cfg_we_i only while the block is idle; the
// block itself does not enforce this.
module sum_checked_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sfr_pkg::BYTE_W-1:0]  cfg_wdata_i,
  input  logic                        rx_valid_i,
  output logic                        rx_ready_o,
  input  logic [sfr_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [sfr_pkg::BYTE_W-1:0]  command_o,
  output logic [sfr_pkg::BYTE_W-1:0]  payload_length_o,
  output logic [sfr_pkg::BYTE_W-1:0]  payload_byte_o,
  output logic [sfr_pkg::INDEX_W-1:0] byte_index_o,
  output logic                        has_payload_o,
  output logic                        checksum_ok_o,
  output logic                        oversize_o,
  output logic                        last_o
);

  sfr_pkg::sfr_cmd_t  cmd;
  sfr_pkg::sfr_stat_t stat;

  // Phase sequencing and run control.
  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Sum, store and output register.
  sfr_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .rx_byte_i        (rx_byte_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .res_ready_i      (res_ready_i),
    .res_valid_o      (res_valid_o),
    .command_o        (command_o),
    .payload_length_o (payload_length_o),
    .payload_byte_o   (payload_byte_o),
    .byte_index_o     (byte_index_o),
    .has_payload_o    (has_payload_o),
    .checksum_ok_o    (checksum_ok_o),
    .oversize_o       (oversize_o),
    .last_o           (last_o)
  );

`ifndef SYNTHESIS
  // Within a run, the next result follows without a bubble.
  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_ready_i && !last_o |=> res_valid_o)
    else $error("result run broke before its last beat");

  // Within a run, the index steps by one.
  a_run_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_ready_i && !last_o |=>
      byte_index_o == $past(byte_index_o) + 4'd1)
    else $error("byte index did not advance within a run");

  // An empty frame yields a single result.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !has_payload_o |-> last_o)
    else $error("empty frame result not marked last");

  // An oversize frame never passes its checksum.
  a_over_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && oversize_o |-> !checksum_ok_o)
    else $error("oversize frame reported good checksum");
`endif

endmodule

FILE: rtl/sfr_ctrl.sv
// Frame parsing controller for the sum-checked frame receiver.
// Sequences reception phases and the result run; uses sfr_pkg.
module sfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  sfr_pkg::sfr_stat_t stat_i,
  output sfr_pkg::sfr_cmd_t  cmd_o
);

  localparam logic [2:0] ST_WAIT = 3'd0;
  localparam logic [2:0] ST_CMD  = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_DATA = 3'd3;
  localparam logic [2:0] ST_CKHI = 3'd4;
  localparam logic [2:0] ST_CKLO = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0] state_q, state_d;
  logic       rx_acc;

  assign rx_ready_o = (state_q != ST_EMIT);
  assign rx_acc     = rx_valid_i && rx_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_WAIT: begin
        if (rx_acc && stat_i.marker_hit) begin
          cmd_o.start = 1'b1;
          state_d     = ST_CMD;
        end
      end
      ST_CMD: begin
        if (rx_acc) begin
          cmd_o.take_cmd = 1'b1;
          state_d        = ST_LEN;
        end
      end
      ST_LEN: begin
        if (rx_acc) begin
          cmd_o.take_len = 1'b1;
          state_d        = stat_i.len_zero ? ST_CKHI : ST_DATA;
        end
      end
      ST_DATA: begin
        if (rx_acc) begin
          cmd_o.take_data = 1'b1;
          if (stat_i.data_done) begin
            state_d = ST_CKHI;
          end
        end
      end
      ST_CKHI: begin
        if (rx_acc) begin
          cmd_o.take_ckhi = 1'b1;
          state_d         = ST_CKLO;
        end
      end
      ST_CKLO: begin
        if (rx_acc) begin
          cmd_o.take_cklo = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // advance one result whenever the output register frees up
        if (stat_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (stat_i.run_last) begin
            state_d = ST_WAIT;
          end
        end
      end
      default: begin
        state_d = ST_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/sfr_dp.sv
// Datapath of the sum-checked frame receiver: marker register, running sum,
// payload store, result counter and output register. Uses sfr_pkg.
module sfr_dp #(
  parameter int unsigned MAX_PAYLOAD = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sfr_pkg::sfr_cmd_t                 cmd_i,
  output sfr_pkg::sfr_stat_t                stat_o,
  input  logic [sfr_pkg::BYTE_W-1:0]        rx_byte_i,
  input  logic                              cfg_we_i,
  input  logic [sfr_pkg::BYTE_W-1:0]        cfg_wdata_i,
  input  logic                              res_ready_i,
  output logic                              res_valid_o,
  output logic [sfr_pkg::BYTE_W-1:0]        command_o,
  output logic [sfr_pkg::BYTE_W-1:0]        payload_length_o,
  output logic [sfr_pkg::BYTE_W-1:0]        payload_byte_o,
  output logic [sfr_pkg::INDEX_W-1:0]       byte_index_o,
  output logic                              has_payload_o,
  output logic                              checksum_ok_o,
  output logic                              oversize_o,
  output logic                              last_o
);

  localparam int unsigned IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [sfr_pkg::BYTE_W-1:0] MaxLen = sfr_pkg::BYTE_W'(MAX_PAYLOAD);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_PAYLOAD);

  logic [sfr_pkg::BYTE_W-1:0] marker_q;
  logic [sfr_pkg::SUM_W-1:0]  sum_q;
  logic [sfr_pkg::BYTE_W-1:0] taken_q;
  logic [sfr_pkg::BYTE_W-1:0] cmd_q;
  logic [sfr_pkg::BYTE_W-1:0] len_q;
  logic [sfr_pkg::BYTE_W-1:0] hi_q;
  logic                       ok_q;
  logic [CW-1:0]              emit_idx_q;
  logic                       res_valid_q;

  logic [sfr_pkg::BYTE_W-1:0] store_mem [MAX_PAYLOAD];

  logic                       over;
  logic                       run_empty;
  logic [CW-1:0]              run_cnt;
  logic                       run_last;
  logic [sfr_pkg::BYTE_W:0]   taken_inc;
  logic [sfr_pkg::BYTE_W-1:0] idx_ext;

  assign over      = (len_q > MaxLen);
  assign run_empty = (len_q == '0);
  assign run_cnt   = over ? MaxCnt : len_q[CW-1:0];
  assign run_last  = run_empty || (emit_idx_q == run_cnt - CW'(1));
  assign taken_inc = {1'b0, taken_q} + 9'd1;
  assign idx_ext   = sfr_pkg::BYTE_W'(emit_idx_q);

  assign stat_o.marker_hit = (rx_byte_i == marker_q);
  assign stat_o.len_zero   = (rx_byte_i == '0);
  assign stat_o.data_done  = (taken_inc >= {1'b0, len_q});
  assign stat_o.run_last   = run_last;
  assign stat_o.out_free   = !res_valid_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q    <= 8'hFF;
      sum_q       <= '0;
      taken_q     <= '0;
      emit_idx_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        marker_q <= cfg_wdata_i;
      end
      if (cmd_i.start) begin
        sum_q   <= sfr_pkg::SUM_W'(rx_byte_i);
        taken_q <= '0;
      end
      if (cmd_i.take_cmd || cmd_i.take_len || cmd_i.take_data) begin
        sum_q <= sum_q + sfr_pkg::SUM_W'(rx_byte_i);
      end
      if (cmd_i.take_data) begin
        taken_q <= taken_inc[sfr_pkg::BYTE_W-1:0];
      end
      if (cmd_i.take_cklo) begin
        emit_idx_q <= '0;
      end else if (cmd_i.emit_load) begin
        emit_idx_q <= emit_idx_q + CW'(1);
      end
      if (cmd_i.emit_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Frame fields and result payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_cmd) begin
      cmd_q <= rx_byte_i;
    end
    if (cmd_i.take_len) begin
      len_q <= rx_byte_i;
    end
    if (cmd_i.take_ckhi) begin
      hi_q <= rx_byte_i;
    end
    if (cmd_i.take_cklo) begin
      ok_q <= !over && (sum_q[sfr_pkg::SUM_W-1:8] == {1'b0, hi_q}) &&
              (sum_q[7:0] == rx_byte_i);
    end
    if (cmd_i.emit_load) begin
      command_o        <= cmd_q;
      payload_length_o <= len_q;
      byte_index_o     <= idx_ext[sfr_pkg::INDEX_W-1:0];
      has_payload_o    <= !run_empty;
      checksum_ok_o    <= ok_q;
      oversize_o       <= over;
      last_o           <= run_last;
    end
  end

  // Payload store: one write port, one registered read into the output.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_data && (taken_q < MaxLen)) begin
      store_mem[taken_q[IW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.emit_load) begin
      payload_byte_o <= run_empty ? '0 : store_mem[emit_idx_q[IW-1:0]];
    end
  end

  assign res_valid_o = res_valid_q;

endmodule
